// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check a condition on every clock out of reset
`define KDM_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("kdm assertion failed");
// check a same-cycle implication
`define KDM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kdm assertion failed");
// check a next-cycle implication
`define KDM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kdm assertion failed");
`endif

// ----- src/kdm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kdm_pkg;
  localparam int NUM_SYMBOLS_DEF = 64;

  localparam logic [7:0] FAIL_CODE = 8'hFF;
  localparam logic [7:0] FIRST_ACCEPT = 8'hFE;

  localparam logic [2:0] CMD_ADD_SYM = 3'd0;
  localparam logic [2:0] CMD_BEGIN   = 3'd1;
  localparam logic [2:0] CMD_PAT     = 3'd2;
  localparam logic [2:0] CMD_END     = 3'd3;
  localparam logic [2:0] CMD_SCAN    = 3'd4;
  localparam logic [2:0] CMD_RESTART = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'd32;

  typedef struct packed {
    logic latch;
    logic clr_step;
    logic map_rd;
    logic map_wr_up;
    logic map_wr_low;
    logic set_err;
    logic begin_exec;
    logic restart;
    logic nl_wr;
    logic tbl_rd;
    logic step_exec;
    logic end_exec;
    logic fill_step;
    logic close;
    logic id_done;
    logic emit;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       clr_done;
    logic       fill_done;
    logic       sym_unknown;
    logic       sym_full;
    logic       open;
    logic       tbl_fail;
    logic       state_full;
    logic       scan_hit;
    logic       out_busy;
  } dp_sts_t;
endpackage
`default_nettype wire

// ----- src/kdm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kdm_dp #(
  parameter int NUM_SYMBOLS = kdm_pkg::NUM_SYMBOLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kdm_pkg::dp_ctl_t  ctl,
  output kdm_pkg::dp_sts_t  sts,
  input  logic [2:0]        in_cmd,
  input  logic [7:0]        in_char_byte,
  input  logic [31:0]       in_pattern_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [31:0]       out_match_id,
  output logic [7:0]        out_current_state
);
  import kdm_pkg::*;

  localparam int SYM_W = $clog2(NUM_SYMBOLS);
  localparam int ADDR_W = 8 + SYM_W;
  localparam int TBL_DEPTH = 256 * (2 ** SYM_W);
  localparam logic [SYM_W-1:0] UNKNOWN_SYM = SYM_W'(NUM_SYMBOLS - 1);
  localparam logic [SYM_W-1:0] SYM_SPACE = SYM_W'(0);
  localparam logic [SYM_W-1:0] SYM_NL = SYM_W'(1);
  localparam logic [SYM_W-1:0] SYM_LPAR = SYM_W'(2);
  localparam logic [SYM_W-1:0] SYM_RPAR = SYM_W'(3);

  function automatic logic [SYM_W-1:0] init_sym(input logic [7:0] ch);
    logic [SYM_W-1:0] s;
    unique case (ch)
      CH_SPACE, CH_TAB, CH_CR: s = SYM_SPACE;
      CH_NL:   s = SYM_NL;
      CH_LPAR: s = SYM_LPAR;
      CH_RPAR: s = SYM_RPAR;
      default: s = UNKNOWN_SYM;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] init_cell(input logic [ADDR_W-1:0] a);
    logic [7:0] v;
    v = FAIL_CODE;
    if (a[ADDR_W-1:SYM_W] == 8'd0) begin
      if (a[SYM_W-1:0] == SYM_SPACE) begin
        v = 8'd0;
      end else if (a[SYM_W-1:0] == SYM_LPAR || a[SYM_W-1:0] == SYM_RPAR) begin
        v = FIRST_ACCEPT;
      end
    end
    return v;
  endfunction

  logic [SYM_W-1:0] map_mem [256];
  logic [7:0]       tbl_mem [TBL_DEPTH];
  logic [31:0]      id_mem  [256];

  logic [2:0]  cmd_r;
  logic [7:0]  char_r;
  logic [31:0] pid_r;
  logic [SYM_W-1:0] map_q;
  logic [7:0]  tbl_q;
  logic [31:0] id_q;
  logic [7:0]  id_idx_r;
  logic [ADDR_W-1:0] tbl_addr_r;
  logic [7:0]  code_r;

  logic [7:0]  nac_r, nac_nxt;
  logic [7:0]  su_r, su_nxt;
  logic [SYM_W-1:0] symu_r, symu_nxt;
  logic [7:0]  bs_r, bs_nxt;
  logic [7:0]  bac_r, bac_nxt;
  logic [7:0]  ss_r, ss_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]  res_status_r, res_status_nxt;
  logic [31:0] res_mid_r, res_mid_nxt;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_mid_r;
  logic [7:0]  out_cur_r;

  logic [7:0] up_ch, low_ch;
  logic [7:0] map_ra;
  logic [ADDR_W-1:0] tbl_ra;
  logic [7:0] new_code;
  logic       tbl_fail, state_full, scan_hit, begin_full;
  logic       map_we, tbl_we;
  logic [7:0] map_wa;
  logic [SYM_W-1:0] map_wd;
  logic [ADDR_W-1:0] tbl_wa;
  logic [7:0] tbl_wd;
  logic [7:0] id_ra;

  assign up_ch = (char_r >= CH_LA && char_r <= CH_LZ) ? char_r - CASE_OFS : char_r;
  assign low_ch = (up_ch >= CH_UA && up_ch <= CH_UZ) ? up_ch + CASE_OFS : up_ch;
  assign map_ra = (cmd_r == CMD_ADD_SYM) ? up_ch : char_r;
  assign new_code = su_r + 8'd1;
  assign tbl_fail = (tbl_q == FAIL_CODE);
  assign state_full = ({1'b0, su_r} + 9'd1) >= {1'b0, nac_r};
  assign scan_hit = (tbl_q >= nac_r);
  assign begin_full = (nac_r - 8'd1) <= su_r;
  assign id_ra = FAIL_CODE - tbl_q;

  always_comb begin
    if (cmd_r == CMD_END) begin
      tbl_ra = {bs_r, SYM_SPACE};
    end else if (cmd_r == CMD_PAT) begin
      tbl_ra = {bs_r, map_q};
    end else begin
      tbl_ra = {ss_r, map_q};
    end
  end

  always_comb begin
    map_we = 1'b0;
    map_wa = cnt_r[7:0];
    map_wd = init_sym(cnt_r[7:0]);
    if (ctl.clr_step) begin
      map_we = 1'b1;
    end else if (ctl.map_wr_up) begin
      map_we = 1'b1;
      map_wa = up_ch;
      map_wd = symu_r;
    end else if (ctl.map_wr_low) begin
      map_we = 1'b1;
      map_wa = low_ch;
      map_wd = symu_r;
    end
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = cnt_r;
    tbl_wd = init_cell(cnt_r);
    if (ctl.clr_step) begin
      tbl_we = 1'b1;
    end else if (ctl.nl_wr) begin
      tbl_we = 1'b1;
      tbl_wa = {bs_r, SYM_NL};
      tbl_wd = bac_r;
    end else if ((ctl.step_exec && cmd_r == CMD_PAT) || ctl.end_exec) begin
      tbl_we = tbl_fail && !state_full;
      tbl_wa = tbl_addr_r;
      tbl_wd = new_code;
    end else if (ctl.fill_step) begin
      tbl_we = 1'b1;
      tbl_wa = {code_r, cnt_r[SYM_W-1:0]};
      tbl_wd = (cnt_r[SYM_W-1:0] == SYM_SPACE) ? code_r : bac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (ctl.map_rd) map_q <= map_mem[map_ra];
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (ctl.tbl_rd) begin
      tbl_q <= tbl_mem[tbl_ra];
      tbl_addr_r <= tbl_ra;
    end
    if (ctl.begin_exec && !begin_full) id_mem[FAIL_CODE - (nac_r - 8'd1)] <= pid_r;
    if (ctl.step_exec) begin
      id_q <= id_mem[id_ra];
      id_idx_r <= id_ra;
    end
    if (ctl.end_exec) code_r <= new_code;
    if (ctl.latch) begin
      cmd_r <= in_cmd;
      char_r <= in_char_byte;
      pid_r <= in_pattern_id;
    end
    if (ctl.emit) begin
      out_status_r <= res_status_r;
      out_mid_r <= res_mid_r;
      out_cur_r <= ss_r;
    end
  end

  always_comb begin
    nac_nxt = nac_r;
    su_nxt = su_r;
    symu_nxt = symu_r;
    bs_nxt = bs_r;
    bac_nxt = bac_r;
    ss_nxt = ss_r;
    cnt_nxt = cnt_r;
    res_status_nxt = res_status_r;
    res_mid_nxt = res_mid_r;
    if (ctl.latch) begin
      res_status_nxt = ST_OK;
      res_mid_nxt = 32'd0;
    end
    if (ctl.clr_step || ctl.fill_step) cnt_nxt = cnt_r + ADDR_W'(1);
    if (ctl.map_wr_low) symu_nxt = symu_r + SYM_W'(1);
    if (ctl.set_err) res_status_nxt = ST_FULL;
    if (ctl.begin_exec) begin
      bs_nxt = 8'd0;
      if (begin_full) begin
        bac_nxt = 8'd0;
        res_status_nxt = ST_FULL;
      end else begin
        nac_nxt = nac_r - 8'd1;
        bac_nxt = nac_r - 8'd1;
      end
    end
    if (ctl.restart) ss_nxt = 8'd0;
    if (ctl.step_exec) begin
      if (cmd_r == CMD_PAT) begin
        if (!tbl_fail) begin
          bs_nxt = tbl_q;
        end else if (state_full) begin
          res_status_nxt = ST_FULL;
        end else begin
          su_nxt = new_code;
          bs_nxt = new_code;
        end
      end else begin
        ss_nxt = tbl_q;
        if (scan_hit) res_status_nxt = (tbl_q == FAIL_CODE) ? ST_FAILED : ST_ACCEPT;
      end
    end
    if (ctl.end_exec && tbl_fail) begin
      if (state_full) begin
        res_status_nxt = ST_FULL;
      end else begin
        su_nxt = new_code;
        cnt_nxt = '0;
      end
    end
    if (ctl.close) begin
      bs_nxt = 8'd0;
      bac_nxt = 8'd0;
    end
    if (ctl.id_done) begin
      if (id_idx_r == 8'd0) begin
        res_mid_nxt = 32'hFFFF_FFFF;
      end else if (id_idx_r == 8'd1) begin
        res_mid_nxt = 32'd0;
      end else begin
        res_mid_nxt = id_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nac_r <= FIRST_ACCEPT;
      su_r <= 8'd0;
      symu_r <= SYM_W'(4);
      bs_r <= 8'd0;
      bac_r <= 8'd0;
      ss_r <= 8'd0;
      cnt_r <= '0;
      res_status_r <= ST_OK;
      res_mid_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      nac_r <= nac_nxt;
      su_r <= su_nxt;
      symu_r <= symu_nxt;
      bs_r <= bs_nxt;
      bac_r <= bac_nxt;
      ss_r <= ss_nxt;
      cnt_r <= cnt_nxt;
      res_status_r <= res_status_nxt;
      res_mid_r <= res_mid_nxt;
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.cmd = cmd_r;
  assign sts.clr_done = &cnt_r;
  assign sts.fill_done = (cnt_r[SYM_W-1:0] == UNKNOWN_SYM);
  assign sts.sym_unknown = (map_q == UNKNOWN_SYM);
  assign sts.sym_full = (symu_r >= UNKNOWN_SYM);
  assign sts.open = (bac_r != 8'd0);
  assign sts.tbl_fail = tbl_fail;
  assign sts.state_full = state_full;
  assign sts.scan_hit = scan_hit;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_match_id = out_mid_r;
  assign out_current_state = out_cur_r;

  `KDM_ASSERT(a_states_below_accept, su_r < nac_r)
  `KDM_ASSERT(a_symbols_bounded, symu_r <= UNKNOWN_SYM)
  `KDM_ASSERT_IMP(a_open_code_is_accept, bac_r != 8'd0, bac_r >= nac_r)
endmodule
`default_nettype wire

// ----- src/kdm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module kdm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kdm_pkg::dp_sts_t  sts,
  output kdm_pkg::dp_ctl_t  ctl
);
  import kdm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_ADD   = 4'd3;
  localparam logic [3:0] S_ADD2  = 4'd4;
  localparam logic [3:0] S_SYM   = 4'd5;
  localparam logic [3:0] S_TBL   = 4'd6;
  localparam logic [3:0] S_ID    = 4'd7;
  localparam logic [3:0] S_END   = 4'd8;
  localparam logic [3:0] S_FILL  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       ready;

  assign ready = (state_r == S_IDLE) && !sts.out_busy;
  assign in_stall = !ready;

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && ready) begin
          ctl.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_OUT;
        unique case (sts.cmd)
          CMD_ADD_SYM: begin
            ctl.map_rd = 1'b1;
            state_nxt = S_ADD;
          end
          CMD_BEGIN: ctl.begin_exec = 1'b1;
          CMD_PAT: begin
            if (sts.open) begin
              ctl.map_rd = 1'b1;
              state_nxt = S_SYM;
            end
          end
          CMD_END: begin
            if (sts.open) begin
              ctl.nl_wr = 1'b1;
              ctl.tbl_rd = 1'b1;
              state_nxt = S_END;
            end
          end
          CMD_SCAN: begin
            ctl.map_rd = 1'b1;
            state_nxt = S_SYM;
          end
          CMD_RESTART: ctl.restart = 1'b1;
          default: state_nxt = S_OUT;
        endcase
      end
      S_ADD: begin
        state_nxt = S_OUT;
        if (sts.sym_unknown) begin
          if (sts.sym_full) begin
            ctl.set_err = 1'b1;
          end else begin
            ctl.map_wr_up = 1'b1;
            state_nxt = S_ADD2;
          end
        end
      end
      S_ADD2: begin
        ctl.map_wr_low = 1'b1;
        state_nxt = S_OUT;
      end
      S_SYM: begin
        ctl.tbl_rd = 1'b1;
        state_nxt = S_TBL;
      end
      S_TBL: begin
        ctl.step_exec = 1'b1;
        state_nxt = (sts.cmd == CMD_SCAN && sts.scan_hit) ? S_ID : S_OUT;
      end
      S_ID: begin
        ctl.id_done = 1'b1;
        state_nxt = S_OUT;
      end
      S_END: begin
        ctl.end_exec = 1'b1;
        if (sts.tbl_fail && !sts.state_full) begin
          state_nxt = S_FILL;
        end else begin
          ctl.close = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_FILL: begin
        ctl.fill_step = 1'b1;
        if (sts.fill_done) begin
          ctl.close = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        ctl.emit = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KDM_ASSERT_IMP(a_fill_after_end, state_r == S_FILL,
    $past(state_r) == S_END || $past(state_r) == S_FILL)
  `KDM_ASSERT_NXT(a_emit_then_idle, ctl.emit, state_r == S_IDLE)
  `KDM_ASSERT_IMP(a_emit_slot_free, ctl.emit, !sts.out_busy)
endmodule
`default_nettype wire

// ----- src/keyword_dfa_builder_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Table-driven keyword DFA: builds keyword patterns and scans bytes, one
// result item per input item. After reset a clearing pass over all
// 256 * 2**clog2(NUM_SYMBOLS) cells (16384 at the default) initializes the
// symbol map and transition table; no item is taken until it ends. An item
// is taken only in idle with the output free, so the next item waits for
// the last one's result. Add symbol reads the map, then writes the upper and
// lower case entries; a pattern char or scan reads the map, then the table,
// and a scan hit then reads the match id; end pattern fills the new
// trailing-space row one table write per cycle.
module keyword_dfa_builder_matcher #(
  parameter int NUM_SYMBOLS = kdm_pkg::NUM_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_byte,
  input  logic [31:0] in_pattern_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_match_id,
  output logic [7:0]  out_current_state
);
  import kdm_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  kdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  kdm_dp #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (in_cmd),
    .in_char_byte      (in_char_byte),
    .in_pattern_id     (in_pattern_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_match_id      (out_match_id),
    .out_current_state (out_current_state)
  );
endmodule
`default_nettype wire

// ----- bench/tb_keyword_dfa_builder_matcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_keyword_dfa_builder_matcher;
  import kdm_pkg::*;

  localparam int NSYM = NUM_SYMBOLS_DEF;
  localparam logic [7:0] SYM_UNK = 8'(NSYM - 1);
  localparam logic [2:0] CMD_BAD6 = 3'd6;
  localparam logic [2:0] CMD_BAD7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] match_id;
    logic [7:0]  state;
  } scan_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [7:0]  in_char_byte;
  logic [31:0] in_pattern_id;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_match_id;
  logic [7:0]  out_current_state;

  keyword_dfa_builder_matcher u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_char_byte(in_char_byte), .in_pattern_id(in_pattern_id),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_match_id(out_match_id), .out_current_state(out_current_state)
  );

  logic [7:0]  sym_map [256];
  logic [7:0]  dfa_next [256 * NSYM];
  logic [31:0] accept_id [256];
  logic [7:0]  next_accept;
  int unsigned syms_used;
  int unsigned states_used;
  logic [7:0]  build_state;
  logic [7:0]  build_accept;
  logic [7:0]  scan_state;

  scan_result_t result_q [$];
  int errors;
  int items_sent;
  int hold_cycles;
  bit quiet;

  logic [7:0] words [64][8];
  int word_len [64];
  int word_cnt;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void dfa_reset();
    foreach (sym_map[i]) sym_map[i] = SYM_UNK;
    sym_map[CH_SPACE] = 8'd0;
    sym_map[CH_TAB] = 8'd0;
    sym_map[CH_CR] = 8'd0;
    sym_map[CH_NL] = 8'd1;
    sym_map[CH_LPAR] = 8'd2;
    sym_map[CH_RPAR] = 8'd3;
    foreach (dfa_next[i]) dfa_next[i] = FAIL_CODE;
    dfa_next[0] = 8'd0;
    dfa_next[2] = FIRST_ACCEPT;
    dfa_next[3] = FIRST_ACCEPT;
    foreach (accept_id[i]) accept_id[i] = '0;
    accept_id[0] = '1;
    next_accept = FIRST_ACCEPT;
    syms_used = 4;
    states_used = 0;
    build_state = 8'd0;
    build_accept = 8'd0;
    scan_state = 8'd0;
  endfunction

  function automatic int sym_of(input logic [7:0] c);
    return (sym_map[c] < NSYM) ? sym_map[c] : SYM_UNK;
  endfunction

  function automatic scan_result_t dfa_step(input logic [2:0] cmd, input logic [7:0] c,
                                            input logic [31:0] pid);
    scan_result_t r;
    logic [7:0] up, low;
    int idx, code;
    r = '0;
    case (cmd)
      CMD_ADD_SYM: begin
        up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
        low = (up >= CH_UA && up <= CH_UZ) ? up + CASE_OFS : up;
        if (sym_map[up] == SYM_UNK) begin
          if (syms_used >= NSYM - 1) r.status = ST_FULL;
          else begin
            sym_map[up] = 8'(syms_used);
            sym_map[low] = 8'(syms_used);
            syms_used++;
          end
        end
      end
      CMD_BEGIN: begin
        if (int'(next_accept) - 1 <= states_used) begin
          build_accept = 8'd0;
          r.status = ST_FULL;
        end else begin
          next_accept--;
          accept_id[FAIL_CODE - next_accept] = pid;
          build_accept = next_accept;
        end
        build_state = 8'd0;
      end
      CMD_PAT: begin
        if (build_accept != 0) begin
          idx = build_state * NSYM + sym_of(c);
          if (dfa_next[idx] == FAIL_CODE) begin
            if (states_used + 1 >= next_accept) r.status = ST_FULL;
            else begin
              states_used++;
              dfa_next[idx] = 8'(states_used);
            end
          end
          if (r.status != ST_FULL) build_state = dfa_next[idx];
        end
      end
      CMD_END: begin
        if (build_accept != 0) begin
          dfa_next[build_state * NSYM + sym_of(CH_NL)] = build_accept;
          idx = build_state * NSYM + sym_of(CH_SPACE);
          if (dfa_next[idx] == FAIL_CODE) begin
            if (states_used + 1 >= next_accept) r.status = ST_FULL;
            else begin
              states_used++;
              code = states_used;
              dfa_next[idx] = 8'(code);
              for (int s = 0; s < NSYM; s++) dfa_next[code * NSYM + s] = build_accept;
              dfa_next[code * NSYM] = 8'(code);
            end
          end
          build_state = 8'd0;
          build_accept = 8'd0;
        end
      end
      CMD_SCAN: begin
        scan_state = dfa_next[scan_state * NSYM + sym_of(c)];
        if (scan_state >= next_accept) begin
          r.status = (scan_state == FAIL_CODE) ? ST_FAILED : ST_ACCEPT;
          r.match_id = accept_id[FAIL_CODE - scan_state];
        end
      end
      CMD_RESTART: scan_state = 8'd0;
      default: ;
    endcase
    r.state = scan_state;
    return r;
  endfunction

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] c,
                           input logic [31:0] pid);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_char_byte <= c;
    in_pattern_id <= pid;
    do @(posedge clk); while (in_stall);
    result_q.push_back(dfa_step(cmd, c, pid));
    items_sent++;
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    int s;
    out_stall = 1'b0;
    s = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (result_q.size() == 0) report("result with no item pending");
        else begin
          scan_result_t e;
          e = result_q.pop_front();
          if (out_status !== e.status)
            report($sformatf("status %0d want %0d", out_status, e.status));
          if (out_match_id !== e.match_id)
            report($sformatf("match_id %h want %h", out_match_id, e.match_id));
          if (out_current_state !== e.state)
            report($sformatf("state %h want %h", out_current_state, e.state));
        end
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (s > 0) begin
        out_stall <= 1'b1;
        s--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) s = gap_len();
      end
    end
  end

  task automatic add_word(input string w, input logic [31:0] pid);
    send_item(CMD_BEGIN, 8'h00, pid);
    for (int i = 0; i < w.len(); i++) send_item(CMD_PAT, w[i], '0);
    send_item(CMD_END, 8'h00, '0);
  endtask

  task automatic scan_text(input string w);
    send_item(CMD_RESTART, 8'h00, '0);
    for (int i = 0; i < w.len(); i++) send_item(CMD_SCAN, w[i], '0);
  endtask

  task automatic test_reset_table();
    scan_text("(x");
    send_item(CMD_SCAN, 8'hFF, '0);
    send_item(CMD_PAT, 8'h41, '0);
    send_item(CMD_END, 8'h00, '0);
    send_item(CMD_BAD6, 8'h00, '1);
    send_item(CMD_BAD7, 8'hFF, '0);
  endtask

  task automatic test_keyword();
    send_item(CMD_ADD_SYM, "k", '0);
    send_item(CMD_ADD_SYM, "E", '0);
    send_item(CMD_ADD_SYM, "y", '0);
    send_item(CMD_ADD_SYM, "(", '0);
    add_word("Key", 32'hFFFF_FFFF);
    add_word("ke", 32'h0000_0000);
    scan_text("KEY ");
    scan_text("ke\n");
    pause_until_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_item(CMD_SCAN, 8'($urandom), $urandom);
    pause_until_drained();
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 7)
      return 8'("A" + $urandom_range(0, 11) + ($urandom_range(0, 1) * 32));
    return 8'($urandom);
  endfunction

  task automatic test_random(input int n);
    int k, w, len;
    logic [7:0] c;
    while (items_sent < n) begin
      quiet = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 99);
      if (k < 35) begin
        len = $urandom_range(1, 6);
        w = (word_cnt < 64) ? word_cnt : $urandom_range(0, 63);
        if (word_cnt < 64) word_cnt++;
        word_len[w] = len;
        send_item(CMD_BEGIN, 8'($urandom), $urandom);
        for (int i = 0; i < len; i++) begin
          words[w][i] = pick_char();
          send_item(CMD_PAT, words[w][i], $urandom);
        end
        if ($urandom_range(0, 9) != 0) send_item(CMD_END, 8'($urandom), $urandom);
      end else if (k < 70 && word_cnt > 0) begin
        w = $urandom_range(0, word_cnt - 1);
        send_item(CMD_RESTART, 8'($urandom), $urandom);
        for (int i = 0; i < word_len[w]; i++) begin
          c = words[w][i];
          if ($urandom_range(0, 15) == 0) c = 8'($urandom);
          if ($urandom_range(0, 1) == 0 && c >= CH_UA && c <= CH_UZ) c = c + CASE_OFS;
          send_item(CMD_SCAN, c, $urandom);
        end
        case ($urandom_range(0, 3))
          0: c = CH_SPACE;
          1: c = CH_NL;
          2: c = CH_RPAR;
          default: c = 8'($urandom);
        endcase
        send_item(CMD_SCAN, c, $urandom);
        if ($urandom_range(0, 1) == 0) send_item(CMD_SCAN, 8'($urandom), $urandom);
      end else if (k < 85) begin
        send_item(CMD_ADD_SYM, ($urandom_range(0, 1) == 0) ? pick_char() : 8'($urandom),
                  $urandom);
      end else begin
        send_item(3'($urandom), 8'($urandom), $urandom);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_RESTART;
    in_char_byte = '0;
    in_pattern_id = '0;
    errors = 0;
    items_sent = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    word_cnt = 0;
    dfa_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_table();
    test_keyword();
    test_backpressure();
    test_random(1850);
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
